>>> rtl/ucal_pkg.sv
// Shared constants, types and the month lookup for the Unix-time-to-calendar block.
package ucal_pkg;

  localparam int unsigned TIME_W = 31;
  localparam int unsigned ZONE_W = 17;
  localparam int unsigned HRS_W  = 20;
  localparam int unsigned DAYS_W = 15;
  localparam int unsigned CYC_W  = 5;

  localparam logic signed [ZONE_W-1:0] ZONE_RESET = -17'sd10800;
  localparam logic [32:0] BASE_1980 = 33'd315532800;

  // Reciprocal multipliers: q = (n * RECIP) >> SHIFT
  localparam logic [31:0] HR_RECIP   = 32'd2443359172;  // floor(2^43/3600), one-step fix-up
  localparam int unsigned HR_SHIFT   = 43;
  localparam logic [14:0] MIN_RECIP  = 15'd17477;       // ceil(2^20/60), exact for n < 3600
  localparam int unsigned MIN_SHIFT  = 20;
  localparam logic [20:0] DAY_RECIP  = 21'd1398102;     // ceil(2^25/24)
  localparam int unsigned DAY_SHIFT  = 25;
  localparam logic [14:0] CYC_RECIP  = 15'd22967;       // ceil(2^25/1461)
  localparam int unsigned CYC_SHIFT  = 25;

  localparam logic [11:0] SEC_PER_HOUR  = 12'd3600;
  localparam logic [10:0] DAYS_PER_CYC  = 11'd1461;
  localparam logic [10:0] YEAR1_START   = 11'd366;
  localparam logic [10:0] YEAR2_START   = 11'd731;
  localparam logic [10:0] YEAR3_START   = 11'd1096;
  localparam logic [10:0] EPOCH_YEAR    = 11'd1980;
  localparam logic [9:0]  LEAP_DAY      = 10'd60;

  // Time split handed from the clock stages to the date stages
  typedef struct packed {
    logic              neg;
    logic [DAYS_W-1:0] days;
    logic [4:0]        hour;
    logic [5:0]        minute;
    logic [5:0]        second;
  } split_t;

  typedef struct packed {
    logic [3:0] month;
    logic [4:0] dom;
  } md_t;

  // Last day-of-year (1-based) of months January..November, common year
  function automatic logic [9:0] month_end(input logic [3:0] k);
    logic [9:0] v;
    case (k)
      4'd0:    v = 10'd31;
      4'd1:    v = 10'd59;
      4'd2:    v = 10'd90;
      4'd3:    v = 10'd120;
      4'd4:    v = 10'd151;
      4'd5:    v = 10'd181;
      4'd6:    v = 10'd212;
      4'd7:    v = 10'd243;
      4'd8:    v = 10'd273;
      4'd9:    v = 10'd304;
      4'd10:   v = 10'd334;
      default: v = 10'd0;
    endcase
    return v;
  endfunction

  // doy is zero-based; leap day of a leap year is handled on its own
  function automatic md_t month_day(input logic [8:0] doy, input logic leap);
    md_t        r;
    logic [9:0] day;
    logic [3:0] k;
    logic [9:0] start;
    day = {1'b0, doy} + 10'd1;
    k = 4'd0;
    start = 10'd0;
    if (leap && day == LEAP_DAY) begin
      r.month = 4'd2;
      r.dom   = 5'd29;
    end else begin
      if (leap && day > LEAP_DAY) begin
        day = day - 10'd1;
      end
      for (int i = 0; i < 11; i++) begin
        if (day > month_end(4'(i))) begin
          k = 4'(i + 1);
          start = month_end(4'(i));
        end
      end
      r.month = k + 4'd1;
      r.dom   = 5'(day - start);
    end
    return r;
  endfunction

endpackage

>>> rtl/unix_seconds_to_calendar_top.sv
// Top level: Unix seconds to calendar date/time, eight-stage pipeline with zone register.
//
//  channel | signals                          | transfer when
//  --------+----------------------------------+-------------------------
//  req     | req_valid req_ready unix_time    | req_valid && req_ready
//  rsp     | rsp_valid rsp_ready year..second | rsp_valid && rsp_ready
//          |   out_of_range                   |
//  cfg     | cfg_we cfg_wdata                 | cfg_we (no wait)
//
// Throughput is one transfer per cycle while the response is not held. The
// stages are set by the reciprocal multiplies (t/3600, hours/24, days/1461)
// each followed by a register before its fix-up product.
// Reset (synchronous) clears every stage valid bit and loads the zone offset
// with -10800 s. When the response is held (rsp_valid && !rsp_ready) the whole
// pipeline freezes in place and req_ready drops; nothing is dropped or
// duplicated.
module unix_seconds_to_calendar_top (
  input  logic                               clk,
  input  logic                               rst,
  // request channel
  input  logic                               req_valid,
  output logic                               req_ready,
  input  logic [ucal_pkg::TIME_W-1:0]        unix_time,
  // response channel
  output logic                               rsp_valid,
  input  logic                               rsp_ready,
  output logic [10:0]                        year,
  output logic [3:0]                         month,
  output logic [4:0]                         day_of_month,
  output logic [4:0]                         hour,
  output logic [5:0]                         minute,
  output logic [5:0]                         second,
  output logic                               out_of_range,
  // zone offset register write
  input  logic                               cfg_we,
  input  logic signed [ucal_pkg::ZONE_W-1:0] cfg_wdata
);
  import ucal_pkg::*;

  logic                     en;          // global pipeline advance
  logic signed [ZONE_W-1:0] zone_offset; // seconds, subtracted with the 1980 base
  logic                     split_vld;
  split_t                   split;

  // advance whenever the output slot is empty or being drained
  assign en        = !rsp_valid || rsp_ready;
  assign req_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      zone_offset <= ZONE_RESET;
    end else if (cfg_we) begin
      zone_offset <= cfg_wdata;
    end
  end

  // stages 1-5: adjust, hours, minutes/seconds, days
  ucal_time_split u_split (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_vld    (req_valid),
    .unix_time (unix_time),
    .zone      (zone_offset),
    .out_vld   (split_vld),
    .split     (split)
  );

  // stages 6-8: cycle/year split, month-day lookup, output register
  ucal_date u_date (
    .clk          (clk),
    .rst          (rst),
    .en           (en),
    .in_vld       (split_vld),
    .split        (split),
    .out_vld      (rsp_valid),
    .year         (year),
    .month        (month),
    .day_of_month (day_of_month),
    .hour         (hour),
    .minute       (minute),
    .second       (second),
    .out_of_range (out_of_range)
  );

  // pre-1980 results carry only the flag
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && out_of_range |->
      year == 11'd0 && month == 4'd0 && day_of_month == 5'd0 &&
      hour == 5'd0 && minute == 6'd0 && second == 6'd0)
    else $error("out-of-range result with nonzero fields");

  // in-range results are legal clock/calendar values
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !out_of_range |->
      month >= 4'd1 && month <= 4'd12 && day_of_month >= 5'd1 &&
      hour <= 5'd23 && minute <= 6'd59 && second <= 6'd59)
    else $error("in-range result field out of bounds");

  // backpressure only comes from a held response
  assert property (@(posedge clk) disable iff (rst)
    !req_ready |-> rsp_valid && !rsp_ready)
    else $error("request stalled without a held response");

endmodule

>>> rtl/ucal_time_split.sv
// Clock stages: zone/epoch adjust, hours by reciprocal, minutes, seconds, day count.
module ucal_time_split (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               en,
  input  logic                               in_vld,
  input  logic [ucal_pkg::TIME_W-1:0]        unix_time,
  input  logic signed [ucal_pkg::ZONE_W-1:0] zone,
  output logic                               out_vld,
  output ucal_pkg::split_t                   split
);
  import ucal_pkg::*;

  // s1: adjusted time
  logic              v1;
  logic              neg1;
  logic [TIME_W-1:0] t1;
  // s2: raw hour quotient
  logic              v2;
  logic              neg2;
  logic [TIME_W-1:0] t2;
  logic [HRS_W-1:0]  hq2;
  // s3: corrected hours and remainder
  logic              v3;
  logic              neg3;
  logic [HRS_W-1:0]  hrs3;
  logic [11:0]       rem3;
  // s4: minutes and day count
  logic              v4;
  logic              neg4;
  logic [HRS_W-1:0]  hrs4;
  logic [11:0]       rem4;
  logic [5:0]        min4;
  logic [DAYS_W-1:0] days4;

  logic signed [32:0] t_adj;
  logic [62:0]        hr_prod;
  logic [31:0]        rem_raw;
  logic               rem_fix;
  logic [25:0]        min_prod;
  logic [40:0]        day_prod;
  logic [11:0]        sec_w;
  logic [HRS_W-1:0]   hour_w;

  assign t_adj   = $signed({2'b00, unix_time}) - $signed(BASE_1980)
                   - 33'(zone);
  assign hr_prod = 63'(t1) * 63'(HR_RECIP);
  assign rem_raw = {1'b0, t2} - 32'(hq2) * 32'(SEC_PER_HOUR);
  assign rem_fix = rem_raw >= 32'(SEC_PER_HOUR);
  assign min_prod = 26'(rem3) * 26'(MIN_RECIP);
  assign day_prod = 41'(hrs3) * 41'(DAY_RECIP);
  assign sec_w  = rem4 - 12'(min4) * 12'd60;
  assign hour_w = hrs4 - HRS_W'(days4) * HRS_W'(24);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      out_vld <= 1'b0;
    end else if (en) begin
      v1 <= in_vld;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      out_vld <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      neg1 <= t_adj[32];
      t1   <= t_adj[TIME_W-1:0];

      neg2 <= neg1;
      t2   <= t1;
      hq2  <= hr_prod[HR_SHIFT +: HRS_W];

      neg3 <= neg2;
      hrs3 <= hq2 + HRS_W'(rem_fix);
      rem3 <= rem_fix ? 12'(rem_raw - 32'(SEC_PER_HOUR)) : rem_raw[11:0];

      neg4  <= neg3;
      hrs4  <= hrs3;
      rem4  <= rem3;
      min4  <= min_prod[MIN_SHIFT +: 6];
      days4 <= day_prod[DAY_SHIFT +: DAYS_W];

      split.neg    <= neg4;
      split.days   <= days4;
      split.hour   <= hour_w[4:0];
      split.minute <= min4;
      split.second <= sec_w[5:0];
    end
  end

endmodule

>>> rtl/ucal_date.sv
// Date stages: four-year cycle split, year within cycle, month and day lookup.
module ucal_date (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_vld,
  input  ucal_pkg::split_t split,
  output logic             out_vld,
  output logic [10:0]      year,
  output logic [3:0]       month,
  output logic [4:0]       day_of_month,
  output logic [4:0]       hour,
  output logic [5:0]       minute,
  output logic [5:0]       second,
  output logic             out_of_range
);
  import ucal_pkg::*;

  // s6: cycle count
  logic              v6;
  split_t            sp6;
  logic [CYC_W-1:0]  cyc6;
  // s7: year and day of year
  logic              v7;
  split_t            sp7;
  logic [10:0]       year7;
  logic [8:0]        doy7;
  logic              leap7;

  logic [29:0]       cyc_prod;
  logic [DAYS_W-1:0] dic_w;
  logic [10:0]       dic;
  logic [1:0]        yo;
  logic [10:0]       ystart;
  logic [10:0]       doy_w;
  md_t               md;

  assign cyc_prod = 30'(split.days) * 30'(CYC_RECIP);
  assign dic_w    = sp6.days - DAYS_W'(cyc6) * DAYS_W'(DAYS_PER_CYC);
  assign dic      = dic_w[10:0];
  assign md       = month_day(doy7, leap7);

  always_comb begin
    if (dic >= YEAR3_START) begin
      yo = 2'd3;
      ystart = YEAR3_START;
    end else if (dic >= YEAR2_START) begin
      yo = 2'd2;
      ystart = YEAR2_START;
    end else if (dic >= YEAR1_START) begin
      yo = 2'd1;
      ystart = YEAR1_START;
    end else begin
      yo = 2'd0;
      ystart = 11'd0;
    end
    doy_w = dic - ystart;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
      v7 <= 1'b0;
      out_vld <= 1'b0;
    end else if (en) begin
      v6 <= in_vld;
      v7 <= v6;
      out_vld <= v7;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sp6  <= split;
      cyc6 <= cyc_prod[CYC_SHIFT +: CYC_W];

      sp7   <= sp6;
      year7 <= EPOCH_YEAR + {4'd0, cyc6, 2'b00} + 11'(yo);
      doy7  <= doy_w[8:0];
      leap7 <= (yo == 2'd0);

      out_of_range <= sp7.neg;
      if (sp7.neg) begin
        year         <= '0;
        month        <= '0;
        day_of_month <= '0;
        hour         <= '0;
        minute       <= '0;
        second       <= '0;
      end else begin
        year         <= year7;
        month        <= md.month;
        day_of_month <= md.dom;
        hour         <= sp7.hour;
        minute       <= sp7.minute;
        second       <= sp7.second;
      end
    end
  end

  // every year in the cycle scheme is at or after the epoch
  assert property (@(posedge clk) disable iff (rst)
    out_vld && !out_of_range |-> year >= EPOCH_YEAR)
    else $error("year below epoch on an in-range result");

endmodule
